>>> rtl/tmr_pkg.sv
// ----------------------------------------------------------------------------
// tmr_pkg
// shared types, register indexes and command codes of the thruster mixer
// ----------------------------------------------------------------------------
package tmr_pkg;

  localparam int unsigned MotorCountDefault = 6;
  localparam int unsigned Axes = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegForceMax = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTorqueMax = 3'd1;
  localparam logic [CfgIdxW-1:0] RegThrustEps = 3'd2;
  localparam logic [CfgIdxW-1:0] RegThrustFwd = 3'd3;
  localparam logic [CfgIdxW-1:0] RegThrustBwd = 3'd4;
  localparam logic [CfgIdxW-1:0] RegDeadband = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMaxStep = 3'd6;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdDrive = 1'b1;

  localparam logic signed [15:0] CmdMax = 16'sd32767;

  typedef struct packed {
    logic              cmd;
    logic [2:0]        coef_motor;
    logic [2:0]        coef_axis;
    logic signed [15:0] coef_value;
    logic signed [15:0] surge_in;
    logic signed [15:0] sway_in;
    logic signed [15:0] heave_in;
    logic signed [15:0] roll_in;
    logic signed [15:0] pitch_in;
    logic signed [15:0] yaw_in;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         motor_number;
    logic signed [15:0] motor_command;
    logic               final_motor;
  } out_word_t;

  typedef struct packed {
    logic [15:0] frc_max;
    logic [15:0] trq_max;
    logic [15:0] thrust_eps;
    logic [15:0] thrust_fwd;
    logic [15:0] thrust_bwd;
    logic [14:0] deadband;
    logic [15:0] max_step;
  } cfg_t;

endpackage

>>> rtl/tmr_ram.sv
// ----------------------------------------------------------------------------
// tmr_ram
// generic single-port-write ram with registered read
// ----------------------------------------------------------------------------
module tmr_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 36
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/tmr_div.sv
// ----------------------------------------------------------------------------
// tmr_div
// restoring divider, one quotient bit per cycle, quotient saturated to 16 bits
// ----------------------------------------------------------------------------
module tmr_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [62:0] num_i,
  input  logic [15:0] den_i,
  output logic        done_o,
  output logic [15:0] quot_o
);

  // divisor is den << 19; quotient at or above 2^16 saturates, so only its low 17 bits count
  logic [62:0] rem_q, rem_d;
  logic [16:0] quot_q, quot_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, sat_q, sat_d;
  logic [35:0] dsh;
  logic [62:0] trial;

  assign dsh = {20'd0, den_i} << cnt_q;
  always_comb begin
    rem_d = rem_q; quot_d = quot_q; cnt_d = cnt_q; busy_d = busy_q; sat_d = sat_q;
    trial = rem_q - {8'd0, dsh[35:0], 19'd0};
    if (start_i) begin
      rem_d = num_i; quot_d = '0; cnt_d = 5'd16; busy_d = 1'b1;
      // quotient >= 2^17 when num >= den << 36
      sat_d = (num_i[62:36] >= {11'd0, den_i});
    end else if (busy_q) begin
      if (rem_q >= {8'd0, dsh[35:0], 19'd0}) begin
        rem_d = trial;
        quot_d = quot_q | (17'd1 << cnt_q);
      end
      if (cnt_q == 5'd0) busy_d = 1'b0;
      else cnt_d = cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0; sat_q <= 1'b0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d; sat_q <= sat_d;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quot_q <= quot_d;
  end

  assign done_o = busy_q && (cnt_q == 5'd0);
  // final quotient includes this cycle's bit
  assign quot_o = (sat_q || quot_d[16]) ? 16'hFFFF : quot_d[15:0];

endmodule

>>> rtl/thruster_mixer_with_ramp.sv
// ----------------------------------------------------------------------------
// thruster_mixer_with_ramp
// thrust allocation mixer with deadband map and command ramp
// ----------------------------------------------------------------------------
// in word: cmd 0 loads one mixing coefficient (no result);
// cmd 1 carries six axis commands and gives one out word per motor,
// in motor order, final_motor set on the last one.
// a drive word runs a sequencer around one shared 34x34 multiplier and a
// bit-serial divider: the six axis forces are formed first, then per
// motor six coefficient reads and multiply/adds, two partial products, a
// 17 step division and the ramp follow (the two products and the division
// are skipped when the thrust is under epsilon or the divisor register is
// zero). in_stall_o stays high until the last out word of the update is
// registered, so no new word is taken while a drive word is in progress.
// each out word waits in an output register while out_stall_i is high; the
// sequencer holds at the ramp step only while that register is full and stalled.
// reset loads the register defaults and clears the previous commands;
// the coefficient table is cleared by a sweep over all MOTOR_COUNT*6
// entries after reset, during which no word is taken (config writes still are).
// ----------------------------------------------------------------------------
module thruster_mixer_with_ramp
  import tmr_pkg::*;
#(
  parameter int unsigned MOTOR_COUNT = MotorCountDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_word_t            in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_word_t           out_word_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned Depth = MOTOR_COUNT * Axes;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned MotW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  localparam logic [3:0] StClear = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StForce = 4'd2;
  localparam logic [3:0] StRead  = 4'd3;
  localparam logic [3:0] StMac   = 4'd4;
  localparam logic [3:0] StMap   = 4'd5;
  localparam logic [3:0] StMul   = 4'd6;
  localparam logic [3:0] StDiv   = 4'd7;
  localparam logic [3:0] StRamp  = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;
  localparam logic [3:0] StWait  = 4'd10;
  localparam logic [3:0] StStart = 4'd11;

  cfg_t cfg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{16'd10240, 16'd2560, 16'd26, 16'd10240, 16'd8192, 15'd2458, 16'd1638};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegForceMax:  cfg_q.frc_max <= cfg_data_i;
        RegTorqueMax: cfg_q.trq_max <= cfg_data_i;
        RegThrustEps: cfg_q.thrust_eps <= cfg_data_i;
        RegThrustFwd: cfg_q.thrust_fwd <= cfg_data_i;
        RegThrustBwd: cfg_q.thrust_bwd <= cfg_data_i;
        RegDeadband:  cfg_q.deadband <= cfg_data_i[14:0];
        RegMaxStep:   cfg_q.max_step <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [3:0]       st_q, st_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [MotW-1:0]  mot_q, mot_d;
  logic [2:0]       ax_q, ax_d;
  logic signed [16:0] axis_q [Axes];
  logic signed [33:0] force_q [Axes];
  logic signed [33:0] force_d;
  logic signed [52:0] acc_q, acc_d;
  logic [51:0]      mag_q, mag_d;
  logic             pos_q, pos_d;
  logic [62:0]      num_q, num_d;
  logic signed [16:0] new_q, new_d;
  logic signed [16:0] prev_q [MOTOR_COUNT];
  out_word_t        out_q, out_d;
  logic             ov_q, ov_d;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [67:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic             ram_we;
  logic [AddrW-1:0] ram_wa, ram_ra;
  logic [15:0]      ram_wd, ram_rd;

  tmr_ram #(.Width(16), .Depth(Depth)) u_ram (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  logic        div_start, div_done;
  logic [15:0] div_den, div_q;
  tmr_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .num_i(num_q),
    .den_i(div_den), .done_o(div_done), .quot_o(div_q)
  );

  logic accept;
  assign in_stall_o = (st_q != StIdle);
  assign accept = in_valid_i && !in_stall_o;

  logic [AddrW-1:0] load_addr, rd_addr;
  assign load_addr = AddrW'(in_word_i.coef_motor * Axes + in_word_i.coef_axis);
  assign rd_addr = AddrW'(mot_q * Axes + ax_q);

  logic [15:0] maxt;
  logic        ovf_out;
  logic signed [16:0] dsg, lst, absl, lo, hi, rmp, nmag;
  logic [16:0] sum;

  assign maxt = pos_q ? cfg_q.thrust_fwd : cfg_q.thrust_bwd;
  assign div_den = maxt;
  assign sum = {2'b0, cfg_q.deadband} + {1'b0, div_q};
  assign dsg = {2'b0, cfg_q.deadband};
  assign lst = prev_q[mot_q];
  assign absl = lst[16] ? -lst : lst;
  assign lo = 17'(18'(lst) - 18'(cfg_q.max_step));
  assign hi = 17'(18'(lst) + 18'(cfg_q.max_step));

  always_comb begin
    logic signed [18:0] lo_w, hi_w;
    lo_w = 19'(lst) - 19'(cfg_q.max_step);
    hi_w = 19'(lst) + 19'(cfg_q.max_step);
    if (absl < dsg && new_q >= dsg) rmp = dsg;
    else if (absl < dsg && new_q <= -dsg) rmp = -dsg;
    else if (19'(new_q) < lo_w) rmp = lo;
    else if (19'(new_q) > hi_w) rmp = hi;
    else rmp = new_q;
  end

  assign ovf_out = sum > 17'd32767;
  assign nmag = ovf_out ? 17'sd32767 : signed'(sum);
  assign force_d = 34'(mul_p);

  always_comb begin
    st_d = st_q; clr_d = clr_q; mot_d = mot_q; ax_d = ax_q;
    acc_d = acc_q; mag_d = mag_q; pos_d = pos_q; num_d = num_q;
    new_d = new_q; out_d = out_q; ov_d = ov_q;
    ram_we = 1'b0; ram_wa = load_addr; ram_wd = in_word_i.coef_value; ram_ra = rd_addr;
    div_start = 1'b0;
    mul_a = '0; mul_b = '0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    unique case (st_q)
      StClear: begin
        ram_we = 1'b1; ram_wa = clr_q; ram_wd = '0;
        if (clr_q == AddrW'(Depth - 1)) st_d = StIdle;
        else clr_d = clr_q + 1'b1;
      end
      StIdle: begin
        if (accept) begin
          if (in_word_i.cmd == CmdLoad) begin
            ram_we = ({1'b0, in_word_i.coef_motor} < 4'(MOTOR_COUNT)) &&
                     (in_word_i.coef_axis < 3'(Axes));
          end else begin
            st_d = StForce; ax_d = '0; mot_d = '0;
          end
        end
      end
      StForce: begin
        mul_a = (ax_q < 3'd3) ? 34'(cfg_q.frc_max) : 34'(cfg_q.trq_max);
        mul_b = 34'(axis_q[ax_q]);
        if (ax_q == 3'd5) begin
          st_d = StRead; ax_d = '0;
        end else ax_d = ax_q + 3'd1;
      end
      StRead: begin
        acc_d = '0; st_d = StMac; ax_d = 3'd1;
      end
      StMac: begin
        // ram_rd holds coefficient of axis ax_q-1; ram reads next
        mul_a = 34'(signed'(ram_rd));
        mul_b = force_q[ax_q - 3'd1];
        acc_d = acc_q + 53'(mul_p);
        if (ax_q == 3'd6) st_d = StMap;
        else ax_d = ax_q + 3'd1;
        ram_ra = AddrW'(mot_q * Axes + ((ax_q == 3'd6) ? 3'd0 : ax_q));
      end
      StMap: begin
        pos_d = !acc_q[52] && (acc_q != '0);
        mag_d = acc_q[52] ? 52'(-acc_q) : 52'(acc_q);
        st_d = StMul;
      end
      StMul: begin
        mul_a = 34'(mag_q[51:8]);
        mul_b = 34'(16'd32768 - {1'b0, cfg_q.deadband});
        // mag >> 8 is at most 44 bits: split in two products
        num_d = 63'(mul_p);
        if ((mag_q < ({36'd0, cfg_q.thrust_eps} << 27)) || mag_q == '0) begin
          new_d = '0; st_d = StRamp;
        end else if (maxt == 16'd0) begin
          new_d = pos_q ? 17'sd32767 : -17'sd32767; st_d = StRamp;
        end else begin
          st_d = StDiv;
        end
        if (st_d == StDiv) begin
          mul_a = 34'(mag_q[51:26]);
          num_d = 63'(mul_p) << 18;
          st_d = StWait;
        end
      end
      StWait: begin
        mul_a = 34'(mag_q[25:8]);
        mul_b = 34'(16'd32768 - {1'b0, cfg_q.deadband});
        num_d = num_q + 63'(mul_p);
        st_d = StStart;
      end
      StStart: begin
        div_start = 1'b1;
        st_d = StDiv;
      end
      StDiv: begin
        if (div_done) begin
          new_d = pos_q ? nmag : -nmag;
          st_d = StRamp;
        end
      end
      StRamp: begin
        if (!ov_q || !out_stall_i) begin
          out_d.motor_number = 3'(mot_q);
          out_d.motor_command = rmp[15:0];
          out_d.final_motor = (mot_q == MotW'(MOTOR_COUNT - 1));
          ov_d = 1'b1;
          st_d = StOut;
        end
      end
      StOut: begin
        if (mot_q == MotW'(MOTOR_COUNT - 1)) st_d = StIdle;
        else begin
          mot_d = mot_q + 1'b1; ax_d = '0; st_d = StRead;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; clr_q <= '0; ov_q <= 1'b0; mot_q <= '0; ax_q <= '0;
      for (int i = 0; i < MOTOR_COUNT; i++) prev_q[i] <= '0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; ov_q <= ov_d; mot_q <= mot_d; ax_q <= ax_d;
      if (st_q == StRamp && st_d == StOut) prev_q[mot_q] <= rmp;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; mag_q <= mag_d; pos_q <= pos_d; new_q <= new_d; out_q <= out_d;
    num_q <= num_d;
    if (accept) begin
      axis_q[0] <= 17'(in_word_i.surge_in);
      axis_q[1] <= -17'(in_word_i.sway_in);
      axis_q[2] <= -17'(in_word_i.heave_in);
      axis_q[3] <= 17'(in_word_i.roll_in);
      axis_q[4] <= -17'(in_word_i.pitch_in);
      axis_q[5] <= -17'(in_word_i.yaw_in);
    end
    if (st_q == StForce) force_q[ax_q] <= force_d;
  end

  assign out_valid_o = ov_q;
  assign out_word_o = out_q;

endmodule

>>> rtl/tmr_checker.sv
// ----------------------------------------------------------------------------
// tmr_checker
// port-level checks of the thruster mixer, bound to the top level
// ----------------------------------------------------------------------------
module tmr_checker
  import tmr_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("out word changed under stall");

  a_cmd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.motor_command != 16'h8000)
    else $error("motor command out of range");

  a_busy_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_word_i.cmd == CmdDrive |=> in_stall_o)
    else $error("drive word not held busy");

  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_word_o.final_motor |=> in_stall_o)
    else $error("accepting mid update");

endmodule

bind thruster_mixer_with_ramp tmr_checker u_tmr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .in_word_i(in_word_i), .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .out_word_o(out_word_o)
);

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking regression of the thruster mixer with command ramp
// ----------------------------------------------------------------------------
// coefficient loads and drive words go in through the input channel; a
// predictor of the mixer, deadband map and ramp forms the expected motor
// commands, which are compared in order with the out words. a directed
// table covers reset values, extremes and out-of-range loads; zero divisors
// and ramp bypass follow, then random phases under several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  import tmr_pkg::*;

  localparam int Motors = 6;
  localparam int CycleLimit = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  thruster_mixer_with_ramp dut (.*);

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [15:0] frc_max, trq_max, thrust_eps, thrust_fwd, thrust_bwd, max_step;
  logic [14:0] deadband;
  logic signed [15:0] coef_tab [Motors][6];
  logic signed [15:0] last_cmd [Motors];
  out_word_t pending_words [$];
  int errors = 0;
  int words_sent = 0;
  int words_seen = 0;
  int cycles = 0;
  bit long_stalls = 1'b1;

  function automatic logic signed [15:0] thrust_to_cmd(logic signed [63:0] s);
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] res;
    logic [15:0] div;
    mag = s < 0 ? -s : s;
    div = s > 0 ? thrust_fwd : thrust_bwd;
    if (s == 0 || mag < ({48'd0, thrust_eps} << 27)) return 16'sd0;
    if (div == 0) res = 64'd32767;
    else begin
      q = ((mag >> 8) * (64'd32768 - deadband)) / ({48'd0, div} << 19);
      res = deadband + q;
      if (res > 64'd32767) res = 64'd32767;
    end
    return s > 0 ? res[15:0] : -res[15:0];
  endfunction

  function automatic logic signed [15:0] ramp_cmd(logic signed [15:0] n,
                                                  logic signed [15:0] prev);
    int d, pl, lo, hi;
    d = deadband;
    pl = prev < 0 ? -prev : prev;
    lo = prev - int'(max_step);
    hi = prev + int'(max_step);
    if (pl < d && n >= d) return 16'(d);
    if (pl < d && n <= -d) return 16'(-d);
    if (n < lo) return 16'(lo);
    if (n > hi) return 16'(hi);
    return n;
  endfunction

  function automatic void predict_word(in_word_t w);
    logic signed [63:0] axis_force [6];
    logic signed [63:0] s;
    logic signed [31:0] v [6];
    logic signed [15:0] r;
    out_word_t o;
    if (w.cmd == CmdLoad) begin
      if (w.coef_motor < Motors && w.coef_axis < 6)
        coef_tab[w.coef_motor][w.coef_axis] = w.coef_value;
      return;
    end
    v[0] = 32'(w.surge_in); v[1] = -32'(w.sway_in); v[2] = -32'(w.heave_in);
    v[3] = 32'(w.roll_in); v[4] = -32'(w.pitch_in); v[5] = -32'(w.yaw_in);
    for (int j = 0; j < 6; j++)
      axis_force[j] = $signed({48'd0, (j < 3 ? frc_max : trq_max)}) * v[j];
    for (int i = 0; i < Motors; i++) begin
      s = 0;
      for (int j = 0; j < 6; j++) s += coef_tab[i][j] * axis_force[j];
      r = ramp_cmd(thrust_to_cmd(s), last_cmd[i]);
      last_cmd[i] = r;
      o.motor_number = 3'(i);
      o.motor_command = r;
      o.final_motor = (i == Motors - 1);
      pending_words.insert(pending_words.size(), o);
    end
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegForceMax: frc_max = val;
      RegTorqueMax: trq_max = val;
      RegThrustEps: thrust_eps = val;
      RegThrustFwd: thrust_fwd = val;
      RegThrustBwd: thrust_bwd = val;
      RegDeadband: deadband = val[14:0];
      RegMaxStep: max_step = val;
      default: ;
    endcase
  endtask

  // drive one word; called just after a falling edge, leaves valid high
  task automatic send_word(in_word_t w);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) in_valid_i <= 1'b0;
    repeat (gap) @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    predict_word(w);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(0, 4000) - 2000);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_word_t rand_word(bit drive);
    in_word_t w;
    w = '0;
    w.coef_motor = 3'($urandom);
    w.coef_axis = 3'($urandom);
    w.coef_value = 16'($urandom);
    w.surge_in = rand_axis(); w.sway_in = rand_axis(); w.heave_in = rand_axis();
    w.roll_in = rand_axis(); w.pitch_in = rand_axis(); w.yaw_in = rand_axis();
    w.cmd = drive ? CmdDrive : CmdLoad;
    if (!drive && $urandom_range(0, 9) != 0) begin
      w.coef_motor = 3'($urandom_range(0, Motors - 1));
      w.coef_axis = 3'($urandom_range(0, 5));
    end
    return w;
  endfunction

  function automatic in_word_t load_word(int m, int a, logic signed [15:0] c);
    in_word_t w;
    w = '0;
    w.cmd = CmdLoad; w.coef_motor = 3'(m); w.coef_axis = 3'(a); w.coef_value = c;
    return w;
  endfunction

  function automatic in_word_t drive_word(logic signed [15:0] a0, logic signed [15:0] a1,
                                          logic signed [15:0] a2, logic signed [15:0] a3,
                                          logic signed [15:0] a4, logic signed [15:0] a5);
    in_word_t w;
    w = '1;
    w.cmd = CmdDrive;
    w.surge_in = a0; w.sway_in = a1; w.heave_in = a2;
    w.roll_in = a3; w.pitch_in = a4; w.yaw_in = a5;
    return w;
  endfunction

  // output side
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (out_valid_o && !out_stall_i) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("out word with nothing expected: motor %0d cmd %0d",
               out_word_o.motor_number, out_word_o.motor_command);
        errors++;
      end else begin
        automatic out_word_t e = pending_words.pop_front();
        if (out_word_o.motor_number !== e.motor_number) begin
          $error("motor_number: expected %0d, got %0d", e.motor_number,
                 out_word_o.motor_number);
          errors++;
        end
        if (out_word_o.motor_command !== e.motor_command) begin
          $error("motor_command: expected %0d, got %0d", e.motor_command,
                 out_word_o.motor_command);
          errors++;
        end
        if (out_word_o.final_motor !== e.final_motor) begin
          $error("final_motor: expected %0d, got %0d", e.final_motor,
                 out_word_o.final_motor);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (!long_stalls) out_stall_i <= 1'b0;
    else if ($urandom_range(0, 49) == 0) out_stall_i <= 1'b1;
    else if (out_stall_i && $urandom_range(0, 9) != 0) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(0, 4) == 0);
  end

  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("thruster_mixer_with_ramp regression: fail");
      $finish;
    end
  end

  typedef struct {
    in_word_t w;
    bit has_fixed;
    logic signed [15:0] fixed_cmd;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic void add_row(in_word_t w, bit has_fixed, logic signed [15:0] fixed_cmd);
    dir_row_t r;
    r.w = w;
    r.has_fixed = has_fixed;
    r.fixed_cmd = fixed_cmd;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  initial begin
    in_word_t w;
    frc_max = 10240; trq_max = 2560; thrust_eps = 26;
    thrust_fwd = 10240; thrust_bwd = 8192; deadband = 2458; max_step = 1638;
    for (int i = 0; i < Motors; i++) begin
      last_cmd[i] = 0;
      for (int j = 0; j < 6; j++) coef_tab[i][j] = 0;
    end
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table: empty table gives zero, then loads, some out of range, and extreme drives
    add_row(drive_word(16'sh7fff, 16'sh8000, 0, 0, 0, 0), 1, 16'sd0);
    add_row(load_word(0, 0, 16'sh7fff), 0, 0);
    add_row(load_word(1, 1, 16'sh8000), 0, 0);
    add_row(load_word(2, 2, 16'sh1000), 0, 0);
    add_row(load_word(3, 3, 16'sh8000), 0, 0);
    add_row(load_word(4, 4, 16'sh1000), 0, 0);
    add_row(load_word(5, 5, 16'sh7fff), 0, 0);
    add_row(load_word(6, 0, 16'sh7fff), 0, 0);
    add_row(load_word(7, 7, 16'sh7fff), 0, 0);
    add_row(load_word(0, 6, 16'sh8000), 0, 0);
    add_row(drive_word(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                       16'sh8000, 16'sh8000), 0, 0);
    add_row(drive_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                       16'sh7fff, 16'sh7fff), 0, 0);
    add_row(drive_word(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                       16'sh7fff, 16'sh7fff), 0, 0);
    add_row(drive_word(0, 0, 0, 0, 0, 0), 0, 0);
    add_row(drive_word(16'sd10, -16'sd10, 16'sd3, -16'sd3, 16'sd1, 0), 0, 0);
    add_row(drive_word(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                       16'sh8000, 16'sh7fff), 0, 0);
    foreach (dir_rows[k]) begin
      send_word(dir_rows[k].w);
      if (dir_rows[k].has_fixed)
        foreach (pending_words[p])
          if (pending_words[p].motor_command !== dir_rows[k].fixed_cmd) begin
            $error("motor_command: expected %0d, got %0d", dir_rows[k].fixed_cmd,
                   pending_words[p].motor_command);
            errors++;
          end
    end
    drain();

    // zero divisors, no ramp, extremes
    write_reg(RegThrustFwd, 16'd0);
    write_reg(RegThrustBwd, 16'd0);
    write_reg(RegMaxStep, 16'hffff);
    write_reg(RegThrustEps, 16'd0);
    send_word(drive_word(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000));
    send_word(drive_word(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(RegForceMax, 16'hffff); write_reg(RegTorqueMax, 16'hffff);
          write_reg(RegThrustEps, 16'd0); write_reg(RegThrustFwd, 16'd1);
          write_reg(RegThrustBwd, 16'hffff); write_reg(RegDeadband, 16'h7fff);
          write_reg(RegMaxStep, 16'd0);
        end
        1: begin
          write_reg(RegForceMax, 16'd0); write_reg(RegTorqueMax, 16'd0);
          write_reg(RegDeadband, 16'd0); write_reg(RegMaxStep, 16'd1);
        end
        2: begin
          write_reg(RegForceMax, 16'd10240); write_reg(RegTorqueMax, 16'd2560);
          write_reg(RegThrustEps, 16'd26); write_reg(RegThrustFwd, 16'd10240);
          write_reg(RegThrustBwd, 16'd8192); write_reg(RegDeadband, 16'd2458);
          write_reg(RegMaxStep, 16'd1638);
        end
        default: begin
          write_reg(RegForceMax, 16'($urandom)); write_reg(RegTorqueMax, 16'($urandom));
          write_reg(RegThrustEps, 16'($urandom_range(0, 300)));
          write_reg(RegThrustFwd, 16'($urandom_range(0, 65535)));
          write_reg(RegThrustBwd, 16'($urandom_range(0, 65535)));
          write_reg(RegDeadband, 16'($urandom_range(0, 32767)));
          write_reg(RegMaxStep, 16'($urandom));
        end
      endcase
      long_stalls = (ph != 3);
      for (int k = 0; k < 52; k++) begin
        w = rand_word($urandom_range(0, 2) != 0);
        send_word(w);
      end
      drain();
    end

    $display("covered %0d input words and %0d motor commands", words_sent, words_seen);
    $display("over reset, extreme and random register settings");
    if (errors == 0) begin
      $display("thruster_mixer_with_ramp regression: pass");
    end else begin
      $display("thruster_mixer_with_ramp regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/tmr_pkg.sv
rtl/tmr_ram.sv
rtl/tmr_div.sv
rtl/thruster_mixer_with_ramp.sv
rtl/tmr_checker.sv
test/tb_top.sv
